@@ hw/rtl/kem_pkg.sv @@
// ----------------------------------------------------------------------------
// kem_pkg: shared constants for the kinematic error model step
// Fixed-point constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package kem_pkg;

  localparam int CORDIC_ITERS_DEF = 16;
  localparam int CORDIC_ITERS_MAX = 30;

  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [31:0] GAIN_INV    = 32'sd652032874;
  localparam logic signed [63:0] TAN_LIMIT   = 64'sd70368744177664;
  localparam logic signed [63:0] PROD_LIMIT  = 64'sd4611686018427387904;

  localparam logic [1:0] REG_STEP_TIME = 2'd0;
  localparam logic [1:0] REG_DT_WB     = 2'd1;
  localparam logic [1:0] REG_DT_STEER  = 2'd2;
  localparam logic [1:0] REG_DT_VEL    = 2'd3;

  localparam logic [30:0] STEP_TIME_RST = 31'd655;
  localparam logic [30:0] DT_WB_RST     = 31'd218;
  localparam logic [16:0] DT_STEER_RST  = 17'd2184;
  localparam logic [16:0] DT_VEL_RST    = 17'd1310;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] r;
    begin
      case (i)
        5'd0: r = 32'sh3243F6A8;   5'd1: r = 32'sh1DAC6705;
        5'd2: r = 32'sh0FADBAFC;   5'd3: r = 32'sh07F56EA6;
        5'd4: r = 32'sh03FEAB76;   5'd5: r = 32'sh01FFD55B;
        5'd6: r = 32'sh00FFFAAA;   5'd7: r = 32'sh007FFF55;
        5'd8: r = 32'sh003FFFEA;   5'd9: r = 32'sh001FFFFD;
        5'd10: r = 32'sh000FFFFF;  5'd11: r = 32'sh0007FFFF;
        5'd12: r = 32'sh0003FFFF;  5'd13: r = 32'sh0001FFFF;
        5'd14: r = 32'sh0000FFFF;  5'd15: r = 32'sh00007FFF;
        5'd16: r = 32'sh00003FFF;  5'd17: r = 32'sh00001FFF;
        5'd18: r = 32'sh00000FFF;  5'd19: r = 32'sh000007FF;
        5'd20: r = 32'sh000003FF;  5'd21: r = 32'sh000001FF;
        5'd22: r = 32'sh000000FF;  5'd23: r = 32'sh0000007F;
        5'd24: r = 32'sh0000003F;  5'd25: r = 32'sh0000001F;
        5'd26: r = 32'sh0000000F;  5'd27: r = 32'sh00000008;
        5'd28: r = 32'sh00000004;  5'd29: r = 32'sh00000002;
        default: r = 32'sh0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ hw/rtl/kem_cordic.sv @@
// ----------------------------------------------------------------------------
// kem_cordic: iterative rotation-mode CORDIC, sine and cosine in Q30
// Range reduction by shifted subtract steps and a quadrant fold, then one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module kem_cordic #(
  parameter int ITERS = kem_pkg::CORDIC_ITERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] ang,
  output logic               done,
  output logic signed [33:0] sin_q30,
  output logic signed [33:0] cos_q30
);
  import kem_pkg::*;

  localparam int IW = $clog2(ITERS + 1);

  typedef enum logic [2:0] {S_IDLE, S_MOD, S_FOLD, S_ITER, S_DONE} st_t;

  st_t                st_r;
  logic signed [47:0] z_r;
  logic signed [33:0] x_r, y_r;
  logic               neg_r;
  logic [IW-1:0]      i_r;
  logic [5:0]         k_r;

  logic signed [33:0] xs, ys;
  logic signed [47:0] at;
  logic signed [47:0] sub_k;
  logic signed [47:0] a_k;

  assign xs    = x_r >>> i_r;
  assign ys    = y_r >>> i_r;
  assign at    = 48'(atan_q30(5'(i_r)));
  assign sub_k = 48'(Q30_TWO_PI) <<< k_r;
  // |z| below 2^46, two pi near 2^33: 14 shifted subtract steps reduce it
  assign a_k   = z_r[47] ? -z_r : z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            z_r  <= 48'(ang) <<< 14;
            k_r  <= 6'd13;
            neg_r <= 1'b0;
            st_r <= S_MOD;
          end
        end
        S_MOD: begin
          // truncating remainder toward zero, magnitude restoring steps
          if (a_k >= sub_k) z_r <= z_r[47] ? z_r + sub_k : z_r - sub_k;
          if (k_r == 6'd0) st_r <= S_FOLD;
          else k_r <= k_r - 6'd1;
        end
        S_FOLD: begin
          x_r <= 34'(GAIN_INV);
          y_r <= '0;
          i_r <= '0;
          st_r <= S_ITER;
          if (z_r > 48'(Q30_PI)) begin
            if (z_r - 48'(Q30_TWO_PI) < -48'(Q30_HALF_PI)) begin
              z_r <= -48'(Q30_PI) - (z_r - 48'(Q30_TWO_PI)); neg_r <= 1'b1;
            end else z_r <= z_r - 48'(Q30_TWO_PI);
          end else if (z_r < -48'(Q30_PI)) begin
            if (z_r + 48'(Q30_TWO_PI) > 48'(Q30_HALF_PI)) begin
              z_r <= 48'(Q30_PI) - (z_r + 48'(Q30_TWO_PI)); neg_r <= 1'b1;
            end else z_r <= z_r + 48'(Q30_TWO_PI);
          end else if (z_r > 48'(Q30_HALF_PI)) begin
            z_r <= 48'(Q30_PI) - z_r; neg_r <= 1'b1;
          end else if (z_r < -48'(Q30_HALF_PI)) begin
            z_r <= -48'(Q30_PI) - z_r; neg_r <= 1'b1;
          end
        end
        S_ITER: begin
          if (!z_r[47]) begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
          end
          if (i_r == IW'(ITERS - 1)) st_r <= S_DONE;
          else i_r <= i_r + 1'b1;
        end
        S_DONE: begin
          sin_q30 <= y_r;
          cos_q30 <= neg_r ? -x_r : x_r;
          done <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/kem_div.sv @@
// ----------------------------------------------------------------------------
// kem_div: radix-2 signed divider for tan = sin * 2^16 / cos
// One quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module kem_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [49:0] num,
  input  logic signed [33:0] den,
  output logic               done,
  output logic signed [63:0] quo
);
  logic        busy_r, neg_r;
  logic [5:0]  cnt_r;
  logic [49:0] q_r;
  logic [50:0] rem_r;
  logic [33:0] d_r;
  logic [50:0] trial;

  assign trial = {rem_r[49:0], q_r[49]} - {17'd0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd49;
        neg_r  <= num[49] ^ den[33];
        q_r    <= num[49] ? 50'(-num) : 50'(num);
        d_r    <= den[33] ? 34'(-den) : 34'(den);
        rem_r  <= '0;
      end else if (busy_r) begin
        if (!trial[50]) begin
          rem_r <= trial;
          q_r   <= {q_r[48:0], 1'b1};
        end else begin
          rem_r <= {rem_r[49:0], q_r[49]};
          q_r   <= {q_r[48:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end else cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  assign quo = neg_r ? -64'($unsigned(q_r)) : 64'($unsigned(q_r));
endmodule

@@ hw/rtl/kinematic_error_model_step.sv @@
// ----------------------------------------------------------------------------
// kinematic_error_model_step: one forward-Euler step of the path error model
// ----------------------------------------------------------------------------
// Each input beat (in_target_speed, in_target_steer) advances the four state
// values (lateral error, heading error, steer angle, speed) by one step and
// returns the new state as one output beat, with out_saturated set when any
// update clipped at the 32-bit limits.
// One shared CORDIC computes sin(heading), then sin/cos of steer and of the
// target steer; one shared divider forms both tangents at a bit per cycle;
// one 32x32 unsigned multiplier builds each product from four partial
// products (operand load, four accumulates, use); a zero cosine skips its
// divide.
// One item at a time: in_ready is high only while idle and the output
// register is empty, so the next beat is taken only after the result beat
// has been accepted. If the receiver stalls, the result holds in the output
// register and no new input is taken until it is accepted.
// Synchronous reset (rst_n low) clears the state to zero and the ratio
// registers to their defaults. cfg_* writes take effect at once.
// ----------------------------------------------------------------------------
module kinematic_error_model_step #(
  parameter int CORDIC_ITERS = kem_pkg::CORDIC_ITERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_target_speed,
  input  logic signed [17:0] in_target_steer,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_lateral_error,
  output logic signed [31:0] out_heading_error,
  output logic signed [31:0] out_steer_angle,
  output logic signed [31:0] out_speed,
  output logic               out_saturated
);
  import kem_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CS0, S_W0, S_CS1, S_W1, S_DV1, S_CS2, S_W2, S_DV2,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_OUT
  } st_t;

  st_t st_r;
  logic [30:0] step_time_r, dt_wb_r;
  logic [16:0] dt_steer_r, dt_vel_r;
  logic signed [31:0] ey_r, yaw_r, dl_r, v_r, vd_r;
  logic signed [17:0] dd_r;
  logic signed [63:0] w_r, a_r, tan1_r, acc_r;
  logic               flag_r;

  // shared CORDIC / divider
  logic               c_start, c_done, d_start, d_done;
  logic signed [31:0] c_ang;
  logic signed [33:0] c_sin, c_cos;
  logic signed [63:0] d_quo;

  kem_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
    .clk, .rst_n, .start(c_start), .ang(c_ang), .done(c_done),
    .sin_q30(c_sin), .cos_q30(c_cos)
  );
  kem_div u_div (
    .clk, .rst_n, .start(d_start), .num(50'(c_sin) <<< 16), .den(c_cos),
    .done(d_done), .quo(d_quo)
  );

  assign c_start = (st_r == S_CS0) || (st_r == S_CS1) || (st_r == S_CS2);
  assign c_ang   = (st_r == S_CS0) ? yaw_r :
                   (st_r == S_CS1) ? dl_r : 32'(dd_r);
  assign d_start = c_done && (c_cos != 0) && (st_r == S_W1 || st_r == S_W2);

  logic signed [63:0] tanv;
  assign tanv = (c_cos != 0) ? 64'sd0 : (c_sin[33] ? -TAN_LIMIT : TAN_LIMIT);

  function automatic logic signed [63:0] rnd(input logic signed [95:0] x,
                                             input int s);
    logic signed [95:0] t;
    begin
      t = (x + (96'sd1 <<< (s - 1))) >>> s;
      return t[63:0];
    end
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] x,
                                             inout logic f);
    begin
      if (x > 64'sd2147483647) begin f = 1'b1; return 32'sh7FFFFFFF; end
      if (x < -64'sd2147483648) begin f = 1'b1; return 32'sh80000000; end
      return x[31:0];
    end
  endfunction

  // single shared multiplier; operands chosen by state
  logic signed [63:0] ma, mb;
  logic signed [63:0] dtan;
  logic [63:0] ua, ub;
  always_comb begin
    dtan = tan1_r - acc_r;
    ma = '0; mb = '0;
    unique case (st_r)
      S_M0: begin ma = 64'(v_r); mb = w_r; end
      S_M1: begin ma = 64'($signed({1'b0, step_time_r})); mb = w_r; end
      S_M2: begin ma = 64'($signed({1'b0, dt_wb_r})); mb = 64'(v_r); end
      S_M3: begin ma = a_r; mb = dtan; end
      S_M4: begin ma = 64'($signed({1'b0, dt_steer_r})); mb = 64'(dl_r) - 64'(dd_r); end
      S_M5: begin ma = 64'($signed({1'b0, dt_vel_r})); mb = 64'(v_r) - 64'(vd_r); end
      default: ;
    endcase
    ua = ma[63] ? -ma : ma;
    ub = mb[63] ? -mb : mb;
  end

  // magnitudes latched, then four 32x32 partial products accumulated
  logic [2:0]         mk_r;
  logic [63:0]        ua_r, ub_r;
  logic               m_neg_r;
  logic [95:0]        pacc_r;
  logic [1:0]         pj;
  logic [31:0]        pa, pb;
  logic [63:0]        pp;
  logic [6:0]         psh;
  logic signed [95:0] mp;
  logic               big, is_mul, mul_done;

  assign pj       = 2'(mk_r - 3'd1);
  assign pa       = pj[1] ? ua_r[63:32] : ua_r[31:0];
  assign pb       = pj[0] ? ub_r[63:32] : ub_r[31:0];
  assign pp       = 64'(pa) * 64'(pb);
  assign psh      = {pj[1] & pj[0], pj[1] ^ pj[0], 5'd0};
  assign mp       = m_neg_r ? -$signed(pacc_r) : $signed(pacc_r);
  assign big      = pacc_r > 96'($unsigned(PROD_LIMIT));
  assign is_mul   = (st_r == S_M0) || (st_r == S_M1) || (st_r == S_M2) ||
                    (st_r == S_M3) || (st_r == S_M4) || (st_r == S_M5);
  assign mul_done = (mk_r == 3'd5);

  assign in_ready = (st_r == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    logic f;
    logic signed [63:0] pterm;
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
      mk_r <= 3'd0;
      step_time_r <= STEP_TIME_RST; dt_wb_r <= DT_WB_RST;
      dt_steer_r <= DT_STEER_RST; dt_vel_r <= DT_VEL_RST;
      ey_r <= '0; yaw_r <= '0; dl_r <= '0; v_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP_TIME: step_time_r <= cfg_data;
          REG_DT_WB:     dt_wb_r <= cfg_data;
          REG_DT_STEER:  dt_steer_r <= cfg_data[16:0];
          REG_DT_VEL:    dt_vel_r <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (is_mul) begin
        if (mk_r == 3'd0) begin
          ua_r <= ua; ub_r <= ub; m_neg_r <= ma[63] ^ mb[63];
          pacc_r <= '0; mk_r <= 3'd1;
        end else if (!mul_done) begin
          pacc_r <= pacc_r + (96'(pp) << psh);
          mk_r <= mk_r + 3'd1;
        end else mk_r <= 3'd0;
      end
      f = flag_r;
      unique case (st_r)
        S_IDLE: if (in_valid && in_ready) begin
          vd_r <= in_target_speed; dd_r <= in_target_steer;
          st_r <= S_CS0;
        end
        S_CS0: st_r <= S_W0;
        S_W0: if (c_done) begin acc_r <= 64'(c_sin); st_r <= S_CS1; end
        S_CS1: begin w_r <= acc_r; st_r <= S_W1; end
        S_W1: if (c_done) begin
          if (c_cos == 0) begin tan1_r <= tanv; st_r <= S_CS2; end
          else st_r <= S_DV1;
        end
        S_DV1: if (d_done) begin tan1_r <= d_quo; st_r <= S_CS2; end
        S_CS2: st_r <= S_W2;
        S_W2: if (c_done) begin
          if (c_cos == 0) begin acc_r <= tanv; st_r <= S_M0; end
          else st_r <= S_DV2;
        end
        S_DV2: if (d_done) begin acc_r <= d_quo; st_r <= S_M0; end
        S_M0: if (mul_done) begin
          // w_r held sin(heading); multiply by speed
          w_r <= rnd(mp, 30); st_r <= S_M1;
        end
        S_M1: if (mul_done) begin
          out_lateral_error <= sat(64'(ey_r) + rnd(mp, 16), f);
          st_r <= S_M2;
        end
        S_M2: if (mul_done) begin a_r <= rnd(mp, 16); st_r <= S_M3; end
        S_M3: if (mul_done) begin
          if (big) pterm = ((a_r[63]) != (dtan[63])) ? -PROD_LIMIT : PROD_LIMIT;
          else pterm = mp[63:0];
          out_heading_error <= sat(64'(yaw_r) + rnd(96'(pterm), 16), f);
          st_r <= S_M4;
        end
        S_M4: if (mul_done) begin
          out_steer_angle <= sat(64'(dl_r) - rnd(mp, 16), f);
          st_r <= S_M5;
        end
        S_M5: if (mul_done) begin
          out_speed <= sat(64'(v_r) - rnd(mp, 16), f);
          st_r <= S_OUT;
        end
        S_OUT: begin
          ey_r <= out_lateral_error; yaw_r <= out_heading_error;
          dl_r <= out_steer_angle; v_r <= out_speed;
          out_saturated <= flag_r;
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      flag_r <= (st_r == S_IDLE) ? 1'b0 : f;
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end
endmodule

@@ hw/rtl/kem_checker.sv @@
// ----------------------------------------------------------------------------
// kem_checker: port-level checks for kinematic_error_model_step
// Handshake stability and one-result-per-item ordering.
// ----------------------------------------------------------------------------
module kem_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_speed
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed))
    else $error("output beat dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");
  a_no_out_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");
endmodule

bind kinematic_error_model_step kem_checker u_kem_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_speed
);
